// ===== hdl/pdet_pkg.sv =====
// Package with item kinds, counts and the step types shared by the event timestamp logic.
`default_nettype none

package pdet_pkg;

    // Default width of the free-running timer.
    localparam int unsigned COUNTER_WIDTH_DEF = 32;

    // Width of the captured tick and of the result fields.
    localparam int unsigned TICK_W = 32;

    // Item kinds.
    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_PPS   = 2'd1;
    localparam logic [1:0] KIND_LOSS  = 2'd2;

    // The pulse count saturates at this value; timing is valid only there.
    localparam logic [1:0] FULL_COUNT = 2'd2;

    // Reset value of the loss timeout register.
    localparam logic [TICK_W-1:0] LOSS_TIMEOUT_RST = '1;

    // One result transaction.
    typedef struct packed {
        logic              time_valid;
        logic [TICK_W-1:0] second_length;
        logic [TICK_W-1:0] since_pulse;
    } t_result;

    // What one item does to the block state.
    typedef struct packed {
        logic       emit;
        logic       pulse_store;
        logic [1:0] count_next;
    } t_step_ctl;

endpackage

`default_nettype wire

// ===== hdl/pdet_calc.sv =====
// Combinational step logic: interval subtraction, validity compare and pulse count update.
`default_nettype none

module pdet_calc #(
    parameter int unsigned COUNTER_WIDTH = pdet_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic [1:0]                kind,
    input  wire logic [COUNTER_WIDTH-1:0]  ticks_w,
    input  wire logic [COUNTER_WIDTH-1:0]  last_pulse,
    input  wire logic [COUNTER_WIDTH-1:0]  prior_pulse,
    input  wire logic [1:0]                pulse_count,
    input  wire logic [pdet_pkg::TICK_W-1:0] loss_timeout,
    output pdet_pkg::t_step_ctl            ctl,
    output pdet_pkg::t_result              result
);

    localparam int unsigned CMP_W =
        (COUNTER_WIDTH > pdet_pkg::TICK_W) ? COUNTER_WIDTH : pdet_pkg::TICK_W;
    typedef logic [CMP_W-1:0] t_cmp;

    logic [COUNTER_WIDTH-1:0] second;
    logic [COUNTER_WIDTH-1:0] since;
    logic                     full;
    logic                     in_time;
    logic                     lost;

    // Differences wrap modulo the counter width.
    assign second  = last_pulse - prior_pulse;
    assign since   = ticks_w - last_pulse;
    assign full    = (pulse_count >= pdet_pkg::FULL_COUNT);
    assign in_time = (since <= second);
    assign lost    = (t_cmp'(since) > t_cmp'(loss_timeout));

    // Decide the state update and the result for this item.
    always_comb begin
        ctl.emit        = 1'b0;
        ctl.pulse_store = 1'b0;
        ctl.count_next  = pulse_count;
        result.time_valid    = 1'b0;
        result.second_length = '0;
        result.since_pulse   = '0;
        case (kind)
            pdet_pkg::KIND_PPS: begin
                ctl.pulse_store = 1'b1;
                if (!full) begin
                    ctl.count_next = pulse_count + 2'd1;
                end
            end
            pdet_pkg::KIND_LOSS: begin
                if (pulse_count != 2'd0 && lost) begin
                    ctl.count_next = 2'd0;
                end
            end
            pdet_pkg::KIND_EVENT: begin
                ctl.emit = 1'b1;
                if (full) begin
                    if (in_time) begin
                        result.time_valid    = 1'b1;
                        result.second_length = pdet_pkg::TICK_W'(second);
                        result.since_pulse   = pdet_pkg::TICK_W'(since);
                    end else begin
                        ctl.count_next = 2'd0;
                    end
                end
            end
            default: begin
                ctl.emit = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/pps_disciplined_event_timestamp_top.sv =====
// Top level of the PPS-disciplined event timestamp block.
// The block accepts one capture transaction per clock cycle when o_stall is low.
// An accepted external event goes through the input register and then the result
// register to the result port; the subtract-and-compare step runs between the
// input register and the result register.
// PPS and loss-check transactions update the pulse state and give no result.
// A waiting result stops new input only when an external event is held in the
// input register behind it. The loss timeout register is always ready.
`default_nettype none

module pps_disciplined_event_timestamp_top #(
    parameter int unsigned COUNTER_WIDTH = pdet_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Capture channel.
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [1:0]                   i_kind,
    input  wire logic [pdet_pkg::TICK_W-1:0]  i_ticks,
    // Result channel.
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic                              o_time_valid,
    output logic [pdet_pkg::TICK_W-1:0]       o_second_length,
    output logic [pdet_pkg::TICK_W-1:0]       o_since_pulse,
    // Loss timeout register write channel.
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [pdet_pkg::TICK_W-1:0]  i_cfg_data
);

    typedef logic [COUNTER_WIDTH-1:0] t_cnt;

    logic                        r_in_valid;
    logic [1:0]                  r_kind;
    logic [pdet_pkg::TICK_W-1:0] r_ticks;
    logic                        r_out_valid;
    pdet_pkg::t_result           r_out;
    t_cnt                        r_last_pulse;
    t_cnt                        r_prior_pulse;
    logic [1:0]                  r_pulse_count;
    logic [pdet_pkg::TICK_W-1:0] r_loss_timeout;

    t_cnt                        ticks_w;
    pdet_pkg::t_step_ctl         ctl;
    pdet_pkg::t_result           result;
    logic                        out_free;
    logic                        in_adv;

    // Captured ticks reduced to the counter width.
    assign ticks_w = t_cnt'(r_ticks);

    pdet_calc #(
        .COUNTER_WIDTH(COUNTER_WIDTH)
    ) u_calc (
        .kind        (r_kind),
        .ticks_w     (ticks_w),
        .last_pulse  (r_last_pulse),
        .prior_pulse (r_prior_pulse),
        .pulse_count (r_pulse_count),
        .loss_timeout(r_loss_timeout),
        .ctl         (ctl),
        .result      (result)
    );

    // Handshake: the input stage moves on when it has no result or the result stage frees up.
    assign out_free = !r_out_valid || !i_stall;
    assign in_adv   = r_in_valid && (!ctl.emit || out_free);
    assign o_stall  = r_in_valid && !in_adv;

    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_valid;
    assign o_time_valid    = r_out.time_valid;
    assign o_second_length = r_out.second_length;
    assign o_since_pulse   = r_out.since_pulse;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_kind  <= i_kind;
            r_ticks <= i_ticks;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_adv && ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (in_adv && ctl.emit) begin
            r_out <= result;
        end
    end

    // Pulse state, updated as each transaction leaves the input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pulse  <= '0;
            r_prior_pulse <= '0;
            r_pulse_count <= 2'd0;
        end else if (in_adv) begin
            r_pulse_count <= ctl.count_next;
            if (ctl.pulse_store) begin
                r_prior_pulse <= r_last_pulse;
                r_last_pulse  <= ticks_w;
            end
        end
    end

    // Loss timeout register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loss_timeout <= pdet_pkg::LOSS_TIMEOUT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_loss_timeout <= i_cfg_data;
        end
    end

    // A valid result never reports an event later than the second length.
    a_valid_in_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.time_valid) |-> (r_out.since_pulse <= r_out.second_length))
        else $error("valid result with since_pulse beyond second_length");

    // An invalid result carries zero intervals.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.time_valid) |->
        (r_out.second_length == '0 && r_out.since_pulse == '0))
        else $error("invalid result with nonzero intervals");

    // A PPS capture always leaves a nonzero pulse count.
    a_pps_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_adv && r_kind == pdet_pkg::KIND_PPS) |=> (r_pulse_count != 2'd0))
        else $error("pulse count zero after PPS capture");

    // A valid result is produced only with a full pulse count.
    a_valid_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_adv && ctl.emit && result.time_valid) |-> (r_pulse_count == pdet_pkg::FULL_COUNT))
        else $error("valid result without two pulses");

    // A result taken into the result register stays until it is delivered.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result lost or changed");

endmodule

`default_nettype wire

// ===== tb/pps_disciplined_event_timestamp_top_test.sv =====
// Self-checking testbench for the PPS-disciplined event timestamp block.
`timescale 1ns / 1ps

module pps_disciplined_event_timestamp_top_test;

    import pdet_pkg::*;

    // Kind 3 has no name in the package; the block ignores it.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CLK_HALF_NS = 6;
    localparam int RESET_CYCLES = 10;
    // Cycles to let a PPS or loss-check transaction settle before a register write.
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS = 10;
    localparam int LIMIT_CYCLES = 200000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [1:0]        i_kind;
    logic [TICK_W-1:0] i_ticks;
    logic              o_valid;
    logic              i_stall;
    logic              o_time_valid;
    logic [TICK_W-1:0] o_second_length;
    logic [TICK_W-1:0] o_since_pulse;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [TICK_W-1:0] i_cfg_data;

    // Predicted pulse state and register copy.
    logic [TICK_W-1:0] pulse_last;
    logic [TICK_W-1:0] pulse_prior;
    logic [1:0]        pulse_cnt;
    logic [TICK_W-1:0] timeout_reg;

    // Expected event timings, oldest first.
    t_result expected_timings[$];

    // Traffic shaping shared by the test tasks and the receiver process.
    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int hold_left;
    logic [TICK_W-1:0] cur_timeout;

    // Run statistics.
    int items_sent;
    int events_checked;
    int valid_timings;
    int cfg_writes;
    int input_stalls;
    int mismatch_count;
    int fail_count;

    pps_disciplined_event_timestamp_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_kind          (i_kind),
        .i_ticks         (i_ticks),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_time_valid    (o_time_valid),
        .o_second_length (o_second_length),
        .o_since_pulse   (o_since_pulse),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // Free-running clock.
    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Predict the effect of one accepted capture transaction.
    task automatic apply_capture(input logic [1:0] kind, input logic [TICK_W-1:0] ticks);
        t_result           timing;
        logic [TICK_W-1:0] second;
        logic [TICK_W-1:0] since;
        second = pulse_last - pulse_prior;
        since  = ticks - pulse_last;
        timing = '0;
        case (kind)
            KIND_PPS: begin
                pulse_prior = pulse_last;
                pulse_last  = ticks;
                if (pulse_cnt < FULL_COUNT) begin
                    pulse_cnt = pulse_cnt + 2'd1;
                end
            end
            KIND_LOSS: begin
                if (pulse_cnt != 2'd0 && since > timeout_reg) begin
                    pulse_cnt = 2'd0;
                end
            end
            KIND_EVENT: begin
                if (pulse_cnt >= FULL_COUNT) begin
                    if (since <= second) begin
                        timing.time_valid    = 1'b1;
                        timing.second_length = second;
                        timing.since_pulse   = since;
                    end else begin
                        pulse_cnt = 2'd0;
                    end
                end
                expected_timings.push_back(timing);
            end
            default: begin
            end
        endcase
    endtask

    // Check results and track accepted transactions on every rising edge.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                events_checked++;
                if (expected_timings.size() == 0) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display({"ERROR: result with nothing expected: ",
                                  "valid=%0b sec=%h since=%h"},
                                 o_time_valid, o_second_length, o_since_pulse);
                    end
                end else begin
                    want = expected_timings.pop_front();
                    if (want.time_valid) begin
                        valid_timings++;
                    end
                    if (o_time_valid !== want.time_valid
                            || o_second_length !== want.second_length
                            || o_since_pulse !== want.since_pulse) begin
                        fail_count++;
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display({"ERROR: timing mismatch: ",
                                      "exp valid=%0b sec=%h since=%h, ",
                                      "got valid=%0b sec=%h since=%h"},
                                     want.time_valid, want.second_length,
                                     want.since_pulse,
                                     o_time_valid, o_second_length, o_since_pulse);
                        end
                    end
                end
            end
            if (i_valid && o_stall) begin
                input_stalls++;
            end
            if (i_valid && !o_stall) begin
                apply_capture(i_kind, i_ticks);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                timeout_reg = i_cfg_data;
            end
        end
    end

    // Result receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offer one capture transaction and wait until it is accepted.
    task automatic send_capture(input logic [1:0] kind, input logic [TICK_W-1:0] ticks);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do begin
                @(negedge i_clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_ticks <= ticks;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        if (kind != KIND_UNUSED) begin
            items_sent++;
        end
    endtask

    // Stop offering input and wait until every expected result has come.
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_timings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the loss timeout register while the block is idle.
    task automatic write_loss_timeout(input logic [TICK_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_timeout = value;
        cfg_writes++;
    endtask

    // Events and checks with no pulse seen, plus an ignored kind.
    task automatic test_reset_state();
        send_capture(KIND_EVENT, 32'h1234_5678);
        send_capture(KIND_LOSS, 32'hFFFF_FFFF);
        send_capture(KIND_UNUSED, 32'hA5A5_A5A5);
        send_capture(KIND_EVENT, 32'h0000_0000);
    endtask

    // Pulse counting, counter wrap, the on-time boundary and a late event.
    task automatic test_pulse_and_wrap();
        send_capture(KIND_PPS, 32'hFFFF_FF00);
        send_capture(KIND_EVENT, 32'hFFFF_FF10);
        send_capture(KIND_PPS, 32'h0000_0100);
        send_capture(KIND_EVENT, 32'h0000_0300);
        send_capture(KIND_EVENT, 32'h0000_01FF);
        send_capture(KIND_EVENT, 32'h0000_0301);
        send_capture(KIND_EVENT, 32'h0000_0150);
    endtask

    // Zero and full-range second lengths and tick values.
    task automatic test_field_extremes();
        send_capture(KIND_PPS, 32'h0000_0000);
        send_capture(KIND_PPS, 32'h0000_0000);
        send_capture(KIND_EVENT, 32'h0000_0000);
        send_capture(KIND_EVENT, 32'h0000_0001);
        send_capture(KIND_PPS, 32'h0000_0000);
        send_capture(KIND_PPS, 32'hFFFF_FFFF);
        send_capture(KIND_EVENT, 32'hFFFF_FFFE);
    endtask

    // Loss check at and just past a zero timeout.
    task automatic test_loss_timeout();
        write_loss_timeout(32'h0000_0000);
        send_capture(KIND_LOSS, 32'hFFFF_FFFF);
        send_capture(KIND_EVENT, 32'hFFFF_FFFF);
        send_capture(KIND_LOSS, 32'h0000_0000);
        send_capture(KIND_EVENT, 32'h0000_0000);
    endtask

    // Long receiver hold-off with back-to-back input, then a full drain.
    task automatic test_backpressure();
        int n;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_loss_timeout(32'h0000_0400);
        @(posedge i_clk);
        hold_request = 80;
        send_capture(KIND_PPS, 32'h8000_0000);
        send_capture(KIND_PPS, 32'h8000_1000);
        for (n = 0; n < 28; n++) begin
            send_capture(KIND_EVENT, 32'h8000_1000 + $urandom_range(32'h1100));
        end
        // Sender pauses until every result is out.
        wait_idle();
        for (n = 0; n < 10; n++) begin
            send_capture(KIND_EVENT, 32'h8000_1000 + $urandom_range(32'h1100));
        end
    endtask

    // Well-formed pulse trains with random content, mixed with noise.
    task automatic test_random_traffic(input int n_items);
        logic [TICK_W-1:0] period;
        logic [TICK_W-1:0] pulse_at;
        int target;
        int pick;
        int steps;
        target = items_sent + n_items;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                send_capture(2'($urandom_range(3)), $urandom);
            end else begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    period = $urandom_range(1000);
                end else if (pick < 85) begin
                    period = $urandom;
                end else if (pick < 90) begin
                    period = '0;
                end else if (pick < 95) begin
                    period = 32'd1;
                end else begin
                    period = '1;
                end
                pulse_at = $urandom;
                send_capture(KIND_PPS, pulse_at - period);
                send_capture(KIND_PPS, pulse_at);
                steps = $urandom_range(8, 2);
                repeat (steps) begin
                    pick = $urandom_range(99);
                    if (pick < 55) begin
                        send_capture(KIND_EVENT, pulse_at + $urandom_range(period));
                    end else if (pick < 70) begin
                        send_capture(KIND_EVENT, pulse_at + period + 1 + $urandom_range(50));
                    end else if (pick < 85) begin
                        send_capture(KIND_LOSS, pulse_at + cur_timeout + $urandom_range(2) - 1);
                    end else begin
                        pulse_at = pulse_at + period + $urandom_range(2) - 1;
                        send_capture(KIND_PPS, pulse_at);
                    end
                end
            end
        end
    endtask

    // Timeout guard.
    initial begin
        #(LIMIT_CYCLES * 2 * CLK_HALF_NS);
        $display("Simulation FAILED");
        $finish;
    end

    // Test sequence.
    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_kind         = KIND_EVENT;
        i_ticks        = '0;
        i_stall        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        pulse_last     = '0;
        pulse_prior    = '0;
        pulse_cnt      = 2'd0;
        timeout_reg    = LOSS_TIMEOUT_RST;
        cur_timeout    = LOSS_TIMEOUT_RST;
        send_idle_pct  = 11;
        recv_stall_pct = 55;
        hold_request   = 0;
        hold_left      = 0;
        items_sent     = 0;
        events_checked = 0;
        valid_timings  = 0;
        cfg_writes     = 0;
        input_stalls   = 0;
        mismatch_count = 0;
        fail_count     = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_pulse_and_wrap();
        test_field_extremes();
        test_loss_timeout();

        write_loss_timeout($urandom_range(2000, 1));
        send_idle_pct  = 11;
        recv_stall_pct = 55;
        test_random_traffic(110);

        test_backpressure();

        write_loss_timeout(32'hFFFF_FFFF);
        send_idle_pct  = 55;
        recv_stall_pct = 11;
        test_random_traffic(110);

        write_loss_timeout(32'h0000_0000);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(110);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_timings.size() != 0) begin
            fail_count++;
        end

        $display("Covered %0d captures, %0d event results (%0d with valid timing).",
                 items_sent, events_checked, valid_timings);
        $display({"Timeout register written %0d times; ",
                  "input held off for %0d cycles; %0d mismatches."},
                 cfg_writes, input_stalls, mismatch_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
